>>> rtl/core/srs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg: shared types for the sorted range set
// Request and response payloads, command codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic [3:0]  read_index;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [4:0]  entry_count;
        logic [63:0] entry_start;
        logic [63:0] entry_end;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ADD_CHK,
        ST_MERGE,
        ST_SUB_CHK,
        ST_SUB_NEXT_FIX,
        ST_SPLIT_OPEN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_OPEN_RD,
        ST_OPEN_WR,
        ST_FINISH,
        ST_RESP
    } t_state;

    // What the controller asks of the datapath in a given cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // capture the request, clear the scan index
        OP_READ,        // read the entry at the scan index, or at the read index
        OP_NEXT,        // advance the scan index
        OP_MERGE_HEAD,  // widen entry at pos with the request, write back
        OP_MERGE_ABS,   // absorb the entry at q into the accumulator
        OP_SUB_TRIM_LO, // write entry lo = e + 1
        OP_SUB_TRIM_HI, // write entry hi = s - 1
        OP_SPLIT_HEAD,  // write entry hi = s - 1, remember tail
        OP_SHIFT_SETUP, // start a down shift from pos+gap to pos
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_OPEN_SETUP,  // start an up shift opening a hole
        OP_OPEN_RD,
        OP_OPEN_WR,
        OP_OPEN_FILL    // write the held entry into the hole
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       set_ok;
        logic       ok_val;
        logic       fill_sel; // 0 request range, 1 split tail
        logic       gap_sel;  // down shift: 0 gap from merge, 1 gap of one
        logic       count_to_pos1;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;    // start >= end
        logic       at_end;   // scan index has reached the count
        logic       full;
        logic       below;    // entry hi < s
        logic       after;    // e < entry lo
        logic       covers;   // s <= lo and e >= hi
        logic       s_le_lo;
        logic       e_ge_hi;
        logic       abs_ok;   // accumulator hi >= entry lo
        logic       shift_done; // down shift has moved its last entry
        logic       open_done;  // up shift has reached the hole
        logic       gap_zero;
    } t_sts;

endpackage

>>> rtl/core/srs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_datapath: range table storage and arithmetic
// Holds the two memories, the count, the scan and shift pointers and the
// response fields; acts on one controller command per cycle.
// ----------------------------------------------------------------------------
module srs_datapath #(
    parameter int ENTRIES = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srs_pkg::t_req  i_req,
    input  srs_pkg::t_ctl  i_ctl,
    output srs_pkg::t_sts  o_sts,
    output srs_pkg::t_rsp  o_rsp
);
    import srs_pkg::*;

    logic [63:0] r_mem_lo [ENTRIES];
    logic [63:0] r_mem_hi [ENTRIES];
    logic [63:0] r_rd_lo, r_rd_hi;

    t_req        r_req;
    logic [CW-1:0] r_count, r_pos, r_q, r_src, r_dst, r_stop;
    logic [63:0] r_acc_lo, r_acc_hi, r_tail_lo, r_tail_hi;
    logic        r_ok;

    logic          n_we;
    logic [CW-1:0] n_waddr, n_raddr;
    logic [63:0]   n_wlo, n_whi;
    logic          n_re;

    always_comb begin
        n_we = 1'b0; n_waddr = r_pos; n_wlo = r_rd_lo; n_whi = r_rd_hi;
        n_re = 1'b0; n_raddr = r_pos;
        case (i_ctl.op)
            OP_READ: begin
                n_re = 1'b1;
                n_raddr = (r_req.cmd == CMD_READ) ? CW'(r_req.read_index) : r_q;
            end
            OP_MERGE_HEAD: begin
                n_we = 1'b1;
                n_wlo = (r_req.range_start < r_rd_lo) ? r_req.range_start : r_rd_lo;
                n_whi = (r_req.range_end > r_rd_hi) ? r_req.range_end : r_rd_hi;
            end
            OP_MERGE_ABS: begin
                n_we = 1'b1;
                n_wlo = (r_rd_lo < r_acc_lo) ? r_rd_lo : r_acc_lo;
                n_whi = (r_rd_hi > r_acc_hi) ? r_rd_hi : r_acc_hi;
            end
            OP_SUB_TRIM_LO: begin
                n_we = 1'b1; n_waddr = r_q; n_wlo = r_req.range_end + 64'd1;
            end
            OP_SUB_TRIM_HI, OP_SPLIT_HEAD: begin
                n_we = 1'b1; n_waddr = r_q; n_whi = r_req.range_start - 64'd1;
            end
            OP_SHIFT_RD, OP_OPEN_RD: begin n_re = 1'b1; n_raddr = r_src; end
            OP_SHIFT_WR, OP_OPEN_WR: begin n_we = 1'b1; n_waddr = r_dst; end
            OP_OPEN_FILL: begin
                n_we = 1'b1; n_waddr = r_dst;
                n_wlo = i_ctl.fill_sel ? r_tail_lo : r_req.range_start;
                n_whi = i_ctl.fill_sel ? r_tail_hi : r_req.range_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem_lo[n_waddr[IW-1:0]] <= n_wlo;
            r_mem_hi[n_waddr[IW-1:0]] <= n_whi;
        end
        if (n_re) begin
            r_rd_lo <= r_mem_lo[n_raddr[IW-1:0]];
            r_rd_hi <= r_mem_hi[n_raddr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ok    <= 1'b1;
        end else begin
            if (i_ctl.set_ok) r_ok <= i_ctl.ok_val;
            case (i_ctl.op)
                OP_LOAD: begin
                    r_req <= i_req; r_q <= '0; r_pos <= '0; r_ok <= 1'b1;
                end
                OP_NEXT: begin r_q <= r_q + 1'b1; r_pos <= r_q + 1'b1; end
                OP_MERGE_HEAD: begin
                    r_acc_lo <= n_wlo; r_acc_hi <= n_whi;
                    r_pos <= r_q; r_q <= r_q + 1'b1;
                end
                OP_MERGE_ABS: begin
                    r_acc_lo <= n_wlo; r_acc_hi <= n_whi; r_q <= r_q + 1'b1;
                end
                OP_SPLIT_HEAD: begin
                    r_tail_lo <= r_req.range_end + 64'd1; r_tail_hi <= r_rd_hi;
                    r_pos <= r_q + 1'b1;
                end
                OP_SHIFT_SETUP: begin
                    if (i_ctl.gap_sel) begin
                        r_dst <= r_q; r_src <= r_q + 1'b1;
                        r_count <= r_count - 1'b1;
                    end else begin
                        r_dst <= r_pos + 1'b1; r_src <= r_q;
                        r_count <= r_count - (r_q - r_pos - 1'b1);
                    end
                    r_stop <= r_count;
                end
                OP_SHIFT_WR: begin r_dst <= r_dst + 1'b1; r_src <= r_src + 1'b1; end
                OP_OPEN_SETUP: begin
                    r_dst <= r_count; r_src <= r_count - 1'b1; r_stop <= r_pos;
                    r_count <= r_count + 1'b1;
                end
                OP_OPEN_WR: begin r_dst <= r_dst - 1'b1; r_src <= r_src - 1'b1; end
                default: ;
            endcase
            if (i_ctl.count_to_pos1) r_count <= r_pos + 1'b1;
        end
    end

    // Down shift runs while src < old count; up shift while dst > hole.
    logic w_down_done, w_up_done;
    assign w_down_done = (r_src >= r_stop);
    assign w_up_done   = (r_dst <= r_stop);

    always_comb begin
        o_sts.cmd        = r_req.cmd;
        o_sts.empty      = (r_req.range_start >= r_req.range_end);
        o_sts.at_end     = (r_q >= r_count);
        o_sts.full       = (r_count >= CW'(ENTRIES));
        o_sts.below      = (r_rd_hi < r_req.range_start);
        o_sts.after      = (r_req.range_end < r_rd_lo);
        o_sts.covers     = (r_req.range_start <= r_rd_lo) && (r_req.range_end >= r_rd_hi);
        o_sts.s_le_lo    = (r_req.range_start <= r_rd_lo);
        o_sts.e_ge_hi    = (r_req.range_end >= r_rd_hi);
        o_sts.abs_ok     = !(r_acc_hi < r_rd_lo);
        o_sts.shift_done = w_down_done;
        o_sts.open_done  = w_up_done;
        o_sts.gap_zero   = (r_q == r_pos + 1'b1);
    end

    logic w_rd_valid;
    assign w_rd_valid = (r_req.cmd == CMD_READ) && (CW'(r_req.read_index) < r_count);

    always_comb begin
        o_rsp.ok          = r_ok;
        o_rsp.entry_count = 5'(r_count);
        o_rsp.entry_start = w_rd_valid ? r_rd_lo : 64'd0;
        o_rsp.entry_end   = w_rd_valid ? r_rd_hi : 64'd0;
    end

endmodule

>>> rtl/core/srs_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_control: command sequencer for the sorted range set
// Steps through scan, merge, trim, split and shift phases of one request.
// ----------------------------------------------------------------------------
module srs_control (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  srs_pkg::t_sts  i_sts,
    output srs_pkg::t_ctl  o_ctl
);
    import srs_pkg::*;

    t_state r_state, n_state;
    // 0 add merge, 1 add insert, 2 sub delete, 3 sub split
    logic [1:0] r_after, n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= 2'd0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        o_ctl = '0;
        o_ctl.op = OP_NONE;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (i_sts.cmd == CMD_READ) begin
                    o_ctl.op = OP_READ; // the datapath reads at the request index
                    n_state = ST_RESP;
                end else if (i_sts.cmd == CMD_ADD || i_sts.cmd == CMD_SUB) begin
                    if (i_sts.empty || i_sts.at_end) begin
                        if (!i_sts.empty && i_sts.cmd == CMD_ADD) begin
                            if (i_sts.full) begin
                                o_ctl.set_ok = 1'b1; n_state = ST_RESP;
                            end else begin
                                o_ctl.op = OP_OPEN_SETUP; n_after = 2'd1;
                                n_state = ST_OPEN_RD;
                            end
                        end else begin
                            n_state = ST_RESP;
                        end
                    end else begin
                        o_ctl.op = OP_READ;
                        n_state = (i_sts.cmd == CMD_ADD) ? ST_ADD_CHK : ST_SUB_CHK;
                    end
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_ADD_CHK: begin
                if (i_sts.below) begin
                    o_ctl.op = OP_NEXT; n_state = ST_FETCH;
                end else if (!i_sts.after) begin
                    o_ctl.op = OP_MERGE_HEAD; n_state = ST_FINISH; n_after = 2'd0;
                end else if (i_sts.full) begin
                    o_ctl.set_ok = 1'b1; n_state = ST_RESP;
                end else begin
                    o_ctl.op = OP_OPEN_SETUP; n_after = 2'd1; n_state = ST_OPEN_RD;
                end
            end
            ST_FINISH: begin
                if (i_sts.at_end) begin
                    o_ctl.count_to_pos1 = 1'b1; n_state = ST_RESP;
                end else begin
                    o_ctl.op = OP_READ; n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (i_sts.abs_ok) begin
                    o_ctl.op = OP_MERGE_ABS; n_state = ST_FINISH;
                end else if (i_sts.gap_zero) begin
                    n_state = ST_RESP;
                end else begin
                    o_ctl.op = OP_SHIFT_SETUP; n_after = 2'd0; n_state = ST_SHIFT_RD;
                end
            end
            ST_SUB_CHK: begin
                if (i_sts.below || i_sts.after) begin
                    o_ctl.op = OP_NEXT; n_state = ST_FETCH;
                end else if (i_sts.covers) begin
                    o_ctl.op = OP_SHIFT_SETUP; o_ctl.gap_sel = 1'b1;
                    n_after = 2'd2; n_state = ST_SHIFT_RD;
                end else if (i_sts.s_le_lo) begin
                    o_ctl.op = OP_SUB_TRIM_LO; n_state = ST_SUB_NEXT_FIX;
                end else if (i_sts.e_ge_hi) begin
                    o_ctl.op = OP_SUB_TRIM_HI; n_state = ST_SUB_NEXT_FIX;
                end else if (i_sts.full) begin
                    o_ctl.set_ok = 1'b1; n_state = ST_RESP;
                end else begin
                    o_ctl.op = OP_SPLIT_HEAD; n_state = ST_SPLIT_OPEN;
                end
            end
            ST_SUB_NEXT_FIX: begin
                o_ctl.op = OP_NEXT; n_state = ST_FETCH;
            end
            ST_SPLIT_OPEN: begin
                o_ctl.op = OP_OPEN_SETUP; n_after = 2'd3; n_state = ST_OPEN_RD;
            end
            ST_SHIFT_RD: begin
                if (i_sts.shift_done) begin
                    // after a merge the command is over; after a delete rescan
                    n_state = (r_after == 2'd2) ? ST_FETCH : ST_RESP;
                end else begin
                    o_ctl.op = OP_SHIFT_RD; n_state = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_ctl.op = OP_SHIFT_WR; n_state = ST_SHIFT_RD;
            end
            ST_OPEN_RD: begin
                o_ctl.op = OP_OPEN_RD;
                if (i_sts.open_done) begin
                    o_ctl.op = OP_OPEN_FILL; o_ctl.fill_sel = (r_after == 2'd3);
                    // after a split, step on to the tail and keep scanning
                    n_state = (r_after == 2'd3) ? ST_SUB_NEXT_FIX : ST_RESP;
                end else begin
                    n_state = ST_OPEN_WR;
                end
            end
            ST_OPEN_WR: begin
                o_ctl.op = OP_OPEN_WR; n_state = ST_OPEN_RD;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/sorted_range_set_add_sub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_set_add_sub: sorted table of disjoint address ranges
// Unions ranges into and removes ranges from the table; reads entries back.
// ----------------------------------------------------------------------------
// A request arrives on the in channel (valid/ready) with a command, a range
// and a read index. Add merges the range with every entry it overlaps or
// inserts it in order; sub trims, deletes or splits entries. Read returns
// the entry at the index together with the count. One response per request
// leaves on the out channel (valid/ready).
// The block works on one request at a time. Add and sub scan the table entry
// by entry, and a shift moves its entries one at a time through the single
// read port of the table memories. Each deleted entry shifts all entries
// behind it, so the work of a sub that removes the whole table grows with
// the square of ENTRIES.
// The response holds in its register while the receiver stalls; no new
// request is taken until it is delivered. Reset empties the table at once
// by clearing the count; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_range_set_add_sub #(
    parameter int ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srs_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srs_pkg::t_rsp  o_out_data
);
    import srs_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 2) + 1;

    t_ctl w_ctl;
    t_sts w_sts;

    srs_control u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .o_out_valid, .i_out_ready, .i_sts(w_sts), .o_ctl(w_ctl)
    );

    srs_datapath #(.ENTRIES(ENTRIES), .IW(IW), .CW(CW)) u_dp (
        .i_clk, .i_rst_n, .i_req(i_in_data), .i_ctl(w_ctl),
        .o_sts(w_sts), .o_rsp(o_out_data)
    );

endmodule

>>> bench/tb_sorted_range_set_add_sub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_range_set_add_sub: self-checking bench for the sorted range set
// Drives add, sub and read requests with random gaps and stalls, predicts
// every response from a model of the range table, and compares them in order.
// ----------------------------------------------------------------------------
module tb_sorted_range_set_add_sub;
    import srs_pkg::*;

    localparam int ENTRIES = 16;
    localparam int N_RANDOM = 1230;

    // Keeps its own copy of the range table and queues the responses that the
    // block must produce, in request order.
    class range_table_scoreboard;
        logic [63:0] lo_tab[ENTRIES];
        logic [63:0] hi_tab[ENTRIES];
        int          count;
        t_rsp        pending[$];
        int          errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function void drop_span(int first, int last);
            int gap;
            gap = last - first;
            if (last <= first || last > count) return;
            for (int q = first; q + gap < count; q++) begin
                lo_tab[q] = lo_tab[q + gap];
                hi_tab[q] = hi_tab[q + gap];
            end
            count -= gap;
        endfunction

        function void open_slot(int at);
            for (int q = count; q > at; q--) begin
                lo_tab[q] = lo_tab[q - 1];
                hi_tab[q] = hi_tab[q - 1];
            end
            count++;
        endfunction

        function bit union_range(logic [63:0] s, logic [63:0] e);
            int pos;
            pos = 0;
            if (s >= e) return 1'b1;
            while (pos < count && hi_tab[pos] < s) pos++;
            if (pos < count && !(e < lo_tab[pos])) begin
                if (s < lo_tab[pos]) lo_tab[pos] = s;
                if (e > hi_tab[pos]) hi_tab[pos] = e;
                for (int q = pos + 1; q < count; q++) begin
                    if (!(hi_tab[pos] < lo_tab[q])) begin
                        if (lo_tab[q] < lo_tab[pos]) lo_tab[pos] = lo_tab[q];
                        if (hi_tab[q] > hi_tab[pos]) hi_tab[pos] = hi_tab[q];
                    end else begin
                        drop_span(pos + 1, q);
                        return 1'b1;
                    end
                end
                count = pos + 1;
                return 1'b1;
            end
            if (count >= ENTRIES) return 1'b0;
            open_slot(pos);
            lo_tab[pos] = s;
            hi_tab[pos] = e;
            return 1'b1;
        endfunction

        function bit remove_range(logic [63:0] s, logic [63:0] e);
            int          pos;
            logic [63:0] lo;
            logic [63:0] hi;
            pos = 0;
            if (s >= e) return 1'b1;
            while (pos < count) begin
                lo = lo_tab[pos];
                hi = hi_tab[pos];
                if (hi < s || e < lo) begin
                    pos++;
                    continue;
                end
                if (s <= lo && e >= hi) begin
                    drop_span(pos, pos + 1);
                    continue;
                end
                if (s <= lo) begin
                    lo_tab[pos] = e + 64'd1;
                end else if (e >= hi) begin
                    hi_tab[pos] = s - 64'd1;
                end else begin
                    if (count >= ENTRIES) return 1'b0;
                    open_slot(pos + 1);
                    lo_tab[pos + 1] = e + 64'd1;
                    hi_tab[pos + 1] = hi;
                    hi_tab[pos] = s - 64'd1;
                end
                pos++;
            end
            return 1'b1;
        endfunction

        function void note_request(t_req r);
            t_rsp x;
            x = '0;
            x.ok = 1'b1;
            case (r.cmd)
                CMD_ADD: begin
                    x.ok = union_range(r.range_start, r.range_end);
                end
                CMD_SUB: begin
                    x.ok = remove_range(r.range_start, r.range_end);
                end
                CMD_READ: begin
                    if (r.read_index < count) begin
                        x.entry_start = lo_tab[r.read_index];
                        x.entry_end = hi_tab[r.read_index];
                    end
                end
                default: ;
            endcase
            x.entry_count = count[4:0];
            pending.push_back(x);
        endfunction

        function void check_response(t_rsp a);
            t_rsp x;
            if (pending.size() == 0) begin
                $error("response with nothing expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.ok !== x.ok) begin
                $error("ok: expected %0d, got %0d", x.ok, a.ok);
                errors++;
            end
            if (a.entry_count !== x.entry_count) begin
                $error("entry_count: expected %0d, got %0d", x.entry_count, a.entry_count);
                errors++;
            end
            if (a.entry_start !== x.entry_start) begin
                $error("entry_start: expected %h, got %h", x.entry_start, a.entry_start);
                errors++;
            end
            if (a.entry_end !== x.entry_end) begin
                $error("entry_end: expected %h, got %h", x.entry_end, a.entry_end);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    range_table_scoreboard table_sb;
    bit stimulus_done = 1'b0;
    // Set while the receiver is made to hold off so the block backs up.
    bit hold_off = 1'b0;

    always #1 i_clk = ~i_clk;

    sorted_range_set_add_sub #(.ENTRIES(ENTRIES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Mostly short gaps, now and then a long one, and stretches with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Addresses are drawn mostly from a narrow window so ranges collide,
    // sometimes near the top or bottom of the 64-bit space, sometimes anywhere.
    function automatic logic [63:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 64'(($urandom_range(0, 400)));
        if (r < 80) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 400));
        if (r < 85) return 64'($urandom_range(0, 3));
        return {$urandom(), $urandom()};
    endfunction

    // Presents one request and holds it until the block accepts it; the model
    // is updated at the accepting edge, so it sees requests in order.
    task automatic send_request(logic [1:0] cmd, logic [63:0] s, logic [63:0] e,
                                logic [3:0] idx);
        t_req r;
        r.cmd = cmd;
        r.range_start = s;
        r.range_end = e;
        r.read_index = idx;
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        table_sb.note_request(r);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        int          r;
        logic [1:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        if (r < 45) cmd = CMD_ADD;
        else if (r < 80) cmd = CMD_SUB;
        else if (r < 97) cmd = CMD_READ;
        else cmd = 2'd3;
        a = pick_addr();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            b = pick_addr();       // may come out empty or reversed
        end else begin
            w = 64'($urandom_range(1, 40));
            b = (a > 64'hFFFF_FFFF_FFFF_FFFF - w) ? 64'hFFFF_FFFF_FFFF_FFFF : a + w;
            if (a == b) a = a - 64'd1;
        end
        send_request(cmd, a, b, 4'($urandom_range(0, 15)));
        idle_sender(pick_gap());
    endtask

    // Receiver: random ready with gaps, and one long hold-off when asked.
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            n = pick_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare every response accepted at a clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) table_sb.check_response(o_out_data);
    end

    initial begin
        table_sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads of an empty table, empty ranges, adjacent ranges
        // that stay apart, a merging add, a trim down to one address, a split,
        // the full-table insert failure, a split on a full table, extremes.
        send_request(CMD_READ, '0, '0, 4'd0);
        send_request(CMD_ADD, 64'd10, 64'd10, 4'd15);
        send_request(CMD_ADD, 64'd20, 64'd5, 4'd0);
        send_request(CMD_ADD, 64'd10, 64'd19, 4'd0);
        send_request(CMD_ADD, 64'd20, 64'd29, 4'd0);
        send_request(CMD_ADD, 64'd40, 64'd49, 4'd0);
        send_request(CMD_ADD, 64'd15, 64'd45, 4'd0);
        send_request(CMD_SUB, 64'd11, 64'd49, 4'd0);
        send_request(CMD_READ, '0, '0, 4'd0);
        send_request(CMD_SUB, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_request(CMD_SUB, 64'hFFFF_FFFF_FFFF_FFF4, 64'hFFFF_FFFF_FFFF_FFF8, 4'd0);
        send_request(CMD_READ, '0, '0, 4'd1);
        send_request(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 4'd15);
        for (int k = 0; k < 15; k++)
            send_request(CMD_ADD, 64'(k * 100), 64'(k * 100 + 50), 4'd0);
        send_request(CMD_ADD, 64'd5000, 64'd5010, 4'd0);
        send_request(CMD_SUB, 64'd110, 64'd120, 4'd0);
        send_request(CMD_READ, '0, '0, 4'd15);
        send_request(CMD_SUB, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);

        // Random traffic, with one long receiver hold-off partway through
        // while the sender keeps offering requests.
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) hold_off = 1'b1;
            send_random();
        end
        i_in_valid <= 1'b0;
        stimulus_done = 1'b1;

        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
